// ===== design/srw_pkg.sv =====
// ============================================================================
// srw_pkg
// Shared types and codes for the random-walk clause search block.
// ============================================================================
package srw_pkg;

    // Fixed field widths
    localparam int LIT_W = 10;  // signed literal
    localparam int TOT_W = 11;  // unsatisfied count
    localparam int CFG_W = 16;  // widest configuration register
    localparam int CFA_W = 2;   // configuration register index

    // Action codes
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_EVAL  = 3'd2;
    localparam logic [2:0] ACT_STEP  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [CFA_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFA_W-1:0] CFG_NUM_VARS  = 2'd1;
    localparam logic [CFA_W-1:0] CFG_NUM_CLS   = 2'd2;

    // Sequencer states
    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_EXEC   = 12'b0000_0000_0100,
        S_SCAN   = 12'b0000_0000_1000,
        S_ROW    = 12'b0000_0001_0000,
        S_LITS   = 12'b0000_0010_0000,
        S_SEL    = 12'b0000_0100_0000,
        S_FLIP   = 12'b0000_1000_0000,
        S_EVAL   = 12'b0001_0000_0000,
        S_DECIDE = 12'b0010_0000_0000,
        S_RDOUT  = 12'b0100_0000_0000,
        S_KMUL   = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== design/srw_ram.sv =====
// ============================================================================
// srw_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module srw_ram
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sat_random_walk_search.sv =====
// ============================================================================
// sat_random_walk_search
// Random-walk local search over a stored clause table and an assignment.
// ============================================================================
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------
//  item in   | action .. accept_draw                     | start & !busy
//  result    | unsat_count flipped_var accepted          | done, one cycle
//            | read_value solved                         |
//  config    | cfg_addr cfg_wdata                        | cfg_we
//
//  Step: a flag scan and literal pick, then a re-evaluation pass; both
//  passes run one clause per cycle through the RAM ports.
//  After reset a clearing pass zeroes all RAMs; busy is high during it.
//  The result receiver cannot stall.
// ============================================================================
module sat_random_walk_search
    import srw_pkg::*;
#(
    parameter int MAX_VARS    = 256,
    parameter int MAX_CLAUSES = 1024,
    parameter int MAX_LITS    = 4,
    parameter int DRAW_BITS   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic                 cfg_we,
    input  logic [CFA_W-1:0]     cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [2:0]           action,
    input  logic [9:0]           clause_index,
    input  logic [1:0]           literal_slot,
    input  logic signed [9:0]    literal,
    input  logic [7:0]           var_index,
    input  logic                 var_value,
    input  logic [DRAW_BITS-1:0] clause_draw,
    input  logic [DRAW_BITS-1:0] literal_draw,
    input  logic [DRAW_BITS-1:0] accept_draw,
    output logic [TOT_W-1:0]     unsat_count,
    output logic [7:0]           flipped_var,
    output logic                 accepted,
    output logic                 read_value,
    output logic                 solved
);

    localparam int CW    = $clog2(MAX_CLAUSES);
    localparam int IW    = CW + 1;
    localparam int VW    = $clog2(MAX_VARS);
    localparam int MW    = $clog2(MAX_LITS + 1);
    localparam int CLR_N = (MAX_CLAUSES > MAX_VARS) ? MAX_CLAUSES : MAX_VARS;
    localparam int CLW   = $clog2(CLR_N);
    localparam int KP_W  = DRAW_BITS + TOT_W;
    localparam int PP_W  = DRAW_BITS + MW;
    localparam logic [8:0]       MV9  = (MAX_VARS > 511) ? 9'd511 : 9'(MAX_VARS);
    localparam logic [TOT_W-1:0] MC11 = (MAX_CLAUSES > 2047) ? 11'd2047
                                                              : TOT_W'(MAX_CLAUSES);

    typedef struct packed {
        logic          ok;
        logic          neg;
        logic [VW-1:0] vidx;
    } lit_t;

    // Decode a stored literal against the variables in use
    function automatic lit_t lit_decode(input logic [LIT_W-1:0] raw, input logic [8:0] ev);
        logic [LIT_W-1:0] mag;
        lit_t             r;
        mag    = raw[LIT_W-1] ? (LIT_W'(0) - raw) : raw;
        r.neg  = raw[LIT_W-1];
        r.ok   = (mag != '0) && (mag <= {1'b0, ev});
        r.vidx = VW'(mag - LIT_W'(1));
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [CFG_W-1:0] thr_reg;
    logic [8:0]       nv_reg;
    logic [TOT_W-1:0] nc_reg;
    logic [8:0]       eff_vars;
    logic [TOT_W-1:0] eff_cls;

    // Latched transaction
    logic [2:0]           act_reg;
    logic [9:0]           ci_reg;
    logic [1:0]           slot_reg;
    logic [LIT_W-1:0]     lit_reg;
    logic [7:0]           vi_reg;
    logic                 vv_reg;
    logic [DRAW_BITS-1:0] cd_reg;
    logic [DRAW_BITS-1:0] ld_reg;
    logic [DRAW_BITS-1:0] ad_reg;

    logic [CLW-1:0]   clr_reg;
    logic [TOT_W-1:0] total_reg;
    logic             bank_reg;
    logic             done_reg;

    logic [TOT_W-1:0] k_reg;
    logic [TOT_W-1:0] seen_reg;
    logic [IW-1:0]    idx_reg;
    logic             sv_reg;
    logic [CW-1:0]    sidx_reg;
    logic [CW-1:0]    chosen_reg;
    logic [MAX_LITS-1:0] vmask_reg;
    logic [VW-1:0]    lvar_reg [MAX_LITS];
    logic [MW-1:0]    pick_reg;
    logic [VW-1:0]    selv_reg;
    logic             old_reg;
    logic             s1_v_reg, s2_v_reg;
    logic [CW-1:0]    s1_idx_reg, s2_idx_reg;
    logic             s1_use_reg, s2_use_reg;
    logic [MAX_LITS-1:0] s2_mask_reg, s2_neg_reg;
    logic [TOT_W-1:0] fresh_reg;

    logic [TOT_W-1:0] cnt_out_reg;
    logic [7:0]       flip_out_reg;
    logic             acc_out_reg;
    logic             rd_out_reg;

    // RAM ports
    logic [LIT_W-1:0] crd [MAX_LITS];
    logic             ard [MAX_LITS];
    logic             frd [2];
    lit_t             row [MAX_LITS];
    logic [MAX_LITS-1:0] row_ok;

    logic             accept;
    logic             clearing;
    logic [CW-1:0]    ci_addr;
    logic [VW-1:0]    vi_addr;
    logic             ci_in;
    logic             vi_in;
    logic             idx_in_use;
    logic             ev_issue;
    logic             flag_cur;
    logic             scan_hit;
    logic [KP_W-1:0]  k_prod;
    logic [PP_W-1:0]  p_prod;
    logic [MW-1:0]    m_cnt;
    logic [VW-1:0]    sel_var;
    logic             sat_any;
    logic             unsat_bit;
    logic             is_step;
    logic             revert;
    logic             fin;
    logic [TOT_W-1:0] fin_total;
    logic             fin_acc;
    logic             fin_rd;
    logic [7:0]       fin_flip;
    logic [VW-1:0]    a_common;
    logic             a_we;
    logic [VW-1:0]    a_waddr;
    logic             a_wdata;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign clearing = (state_reg == S_CLEAR);
    assign eff_vars = (32'(nv_reg) < MAX_VARS) ? nv_reg : MV9;
    assign eff_cls  = (32'(nc_reg) < MAX_CLAUSES) ? nc_reg : MC11;
    assign ci_addr  = CW'(ci_reg);
    assign vi_addr  = VW'(vi_reg);
    assign ci_in    = (32'(ci_reg) < MAX_CLAUSES) && (32'(slot_reg) < MAX_LITS);
    assign vi_in    = 32'(vi_reg) < MAX_VARS;
    assign idx_in_use = 32'(idx_reg) < 32'(eff_cls);
    assign ev_issue = 32'(idx_reg) < MAX_CLAUSES;
    assign is_step  = (act_reg == ACT_STEP);

    // Literal decode of the clause row on the RAM outputs
    always_comb
    begin
        for (int j = 0; j < MAX_LITS; j++)
        begin
            row[j]    = lit_decode(crd[j], eff_vars);
            row_ok[j] = row[j].ok;
        end
    end

    assign m_cnt  = MW'($countones(row_ok));
    assign k_prod = KP_W'(cd_reg) * KP_W'(total_reg);
    assign p_prod = PP_W'(ld_reg) * PP_W'(m_cnt);

    // Pick the chosen valid literal
    always_comb
    begin
        logic [MW-1:0] n;
        logic          found;
        n       = '0;
        found   = 1'b0;
        sel_var = '0;
        for (int j = 0; j < MAX_LITS; j++)
        begin
            if (vmask_reg[j])
            begin
                if (!found && n == pick_reg)
                begin
                    sel_var = lvar_reg[j];
                    found   = 1'b1;
                end
                n = n + MW'(1);
            end
        end
    end

    // Clause evaluation at the last pipeline stage
    always_comb
    begin
        sat_any = 1'b0;
        for (int j = 0; j < MAX_LITS; j++)
        begin
            sat_any = sat_any | (s2_mask_reg[j] & (ard[j] ^ s2_neg_reg[j]));
        end
        unsat_bit = s2_use_reg & !sat_any;
    end

    assign flag_cur = bank_reg ? frd[1] : frd[0];
    assign scan_hit = sv_reg && flag_cur && (seen_reg == k_reg);
    assign revert   = is_step && (fresh_reg > total_reg) && (32'(ad_reg) > 32'(thr_reg));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fin        = 1'b0;
        fin_total  = total_reg;
        fin_acc    = 1'b0;
        fin_rd     = 1'b0;
        fin_flip   = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (act_reg)
                    ACT_EVAL: state_next = S_EVAL;
                    ACT_READ: state_next = S_RDOUT;
                    ACT_STEP:
                    begin
                        if (total_reg != '0)
                        begin
                            state_next = S_KMUL;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_KMUL:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_ROW;
                end
                else if (!sv_reg && !idx_in_use)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ROW:    state_next = S_LITS;
            S_LITS:
            begin
                if (m_cnt == '0)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:    state_next = S_FLIP;
            S_FLIP:   state_next = S_EVAL;
            S_EVAL:
            begin
                if (!ev_issue && !s1_v_reg && !s2_v_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                fin        = 1'b1;
                fin_flip   = is_step ? 8'(selv_reg) : 8'd0;
                fin_acc    = is_step && !revert;
                fin_total  = revert ? total_reg : fresh_reg;
                state_next = S_IDLE;
            end
            S_RDOUT:
            begin
                fin        = 1'b1;
                fin_rd     = vi_in & ard[0];
                state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            bank_reg  <= 1'b0;
            done_reg  <= 1'b0;
            sv_reg    <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            thr_reg   <= '0;
            nv_reg    <= 9'd256;
            nc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (clearing)
            begin
                clr_reg <= clr_reg + CLW'(1);
            end
            if (state_reg == S_DECIDE && !revert)
            begin
                total_reg <= fresh_reg;
                bank_reg  <= !bank_reg;
            end
            // Scan pipeline valid
            if (state_reg == S_SCAN)
            begin
                sv_reg <= !scan_hit && idx_in_use;
            end
            else
            begin
                sv_reg <= 1'b0;
            end
            // Evaluation pipeline valids
            if (state_reg == S_EVAL)
            begin
                s1_v_reg <= ev_issue;
                s2_v_reg <= s1_v_reg;
            end
            else
            begin
                s1_v_reg <= 1'b0;
                s2_v_reg <= 1'b0;
            end
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_THRESHOLD: thr_reg <= cfg_wdata;
                    CFG_NUM_VARS:  nv_reg  <= cfg_wdata[8:0];
                    CFG_NUM_CLS:   nc_reg  <= cfg_wdata[TOT_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            ci_reg   <= clause_index;
            slot_reg <= literal_slot;
            lit_reg  <= literal;
            vi_reg   <= var_index;
            vv_reg   <= var_value;
            cd_reg   <= clause_draw;
            ld_reg   <= literal_draw;
            ad_reg   <= accept_draw;
        end
        if (state_reg == S_KMUL)
        begin
            k_reg    <= k_prod[DRAW_BITS +: TOT_W];
            seen_reg <= '0;
            idx_reg  <= '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (sv_reg && flag_cur && !scan_hit)
            begin
                seen_reg <= seen_reg + TOT_W'(1);
            end
            if (scan_hit)
            begin
                chosen_reg <= sidx_reg;
            end
            else if (idx_in_use)
            begin
                sidx_reg <= idx_reg[CW-1:0];
                idx_reg  <= idx_reg + IW'(1);
            end
        end
        if (state_reg == S_LITS)
        begin
            vmask_reg <= row_ok;
            pick_reg  <= p_prod[DRAW_BITS +: MW];
            for (int j = 0; j < MAX_LITS; j++)
            begin
                lvar_reg[j] <= row[j].vidx;
            end
        end
        if (state_reg == S_SEL)
        begin
            selv_reg <= sel_var;
        end
        if (state_reg == S_FLIP)
        begin
            old_reg <= ard[0];
        end
        // Evaluation pass start
        if (state_reg == S_FLIP || (state_reg == S_EXEC && act_reg == ACT_EVAL))
        begin
            idx_reg   <= '0;
            fresh_reg <= '0;
        end
        if (state_reg == S_EVAL)
        begin
            if (ev_issue)
            begin
                s1_idx_reg <= idx_reg[CW-1:0];
                s1_use_reg <= idx_in_use;
                idx_reg    <= idx_reg + IW'(1);
            end
            s2_idx_reg <= s1_idx_reg;
            s2_use_reg <= s1_use_reg;
            for (int j = 0; j < MAX_LITS; j++)
            begin
                s2_mask_reg[j] <= row[j].ok;
                s2_neg_reg[j]  <= row[j].neg;
            end
            if (s2_v_reg && unsat_bit)
            begin
                fresh_reg <= fresh_reg + TOT_W'(1);
            end
        end
        // Result registers
        if (fin)
        begin
            cnt_out_reg  <= fin_total;
            flip_out_reg <= fin_flip;
            acc_out_reg  <= fin_acc;
            rd_out_reg   <= fin_rd;
        end
    end

    // Clause slot RAMs, one per literal position
    generate
        for (genvar j = 0; j < MAX_LITS; j++)
        begin : g_cls
            logic          c_we;
            logic [CW-1:0] c_waddr;
            assign c_we    = clearing || (state_reg == S_EXEC && act_reg == ACT_LOAD
                                          && ci_in && 32'(slot_reg) == j);
            assign c_waddr = clearing ? clr_reg[CW-1:0] : ci_addr;
            srw_ram #(.WIDTH(LIT_W), .DEPTH(MAX_CLAUSES)) u_cls (
                .clk   (clk),
                .we    (c_we),
                .waddr (c_waddr),
                .wdata (clearing ? LIT_W'(0) : lit_reg),
                .raddr ((state_reg == S_EVAL) ? idx_reg[CW-1:0] : chosen_reg),
                .rdata (crd[j])
            );
        end
    endgenerate

    // Assignment write port shared by all copies
    assign a_common = (state_reg == S_SEL) ? sel_var : vi_addr;
    assign a_we     = clearing
                   || (state_reg == S_EXEC && act_reg == ACT_SET && vi_in)
                   || (state_reg == S_FLIP)
                   || (state_reg == S_DECIDE && revert);
    assign a_waddr  = clearing ? clr_reg[VW-1:0]
                    : ((state_reg == S_EXEC) ? vi_addr : selv_reg);
    assign a_wdata  = clearing ? 1'b0
                    : (state_reg == S_EXEC) ? vv_reg
                    : (state_reg == S_FLIP) ? !ard[0] : old_reg;

    // Assignment copies, one read port per literal position
    generate
        for (genvar j = 0; j < MAX_LITS; j++)
        begin : g_asg
            srw_ram #(.WIDTH(1), .DEPTH(MAX_VARS)) u_asg (
                .clk   (clk),
                .we    (a_we),
                .waddr (a_waddr),
                .wdata (a_wdata),
                .raddr ((state_reg == S_EVAL) ? row[j].vidx : a_common),
                .rdata (ard[j])
            );
        end
    endgenerate

    // Two flag banks: current one read by the scan, the other rebuilt by evaluation
    generate
        for (genvar b = 0; b < 2; b++)
        begin : g_flg
            logic f_we;
            assign f_we = clearing
                       || (state_reg == S_EVAL && s2_v_reg && (bank_reg != 1'(b)));
            srw_ram #(.WIDTH(1), .DEPTH(MAX_CLAUSES)) u_flg (
                .clk   (clk),
                .we    (f_we),
                .waddr (clearing ? clr_reg[CW-1:0] : s2_idx_reg),
                .wdata (clearing ? 1'b0 : unsat_bit),
                .raddr (idx_reg[CW-1:0]),
                .rdata (frd[b])
            );
        end
    endgenerate

    assign done        = done_reg;
    assign unsat_count = cnt_out_reg;
    assign flipped_var = flip_out_reg;
    assign accepted    = acc_out_reg;
    assign read_value  = rd_out_reg;
    assign solved      = (cnt_out_reg == '0);

endmodule

// ===== design/srw_checker.sv =====
// ============================================================================
// srw_checker
// Port-level checks on the search block's transaction and result timing.
// ============================================================================
module srw_props
    import srw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [TOT_W-1:0] unsat_count,
    input logic             solved
);

    // One result per transaction, never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe high on two cycles in a row");

    // An accepted transaction makes the block busy
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // The block is free again while its result is shown
    a_free_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // Solved flag agrees with the count
    a_solved: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (solved == (unsat_count == '0)))
        else $error("solved disagrees with unsat_count");

endmodule

bind sat_random_walk_search srw_props u_srw_props (.*);
